// ===== rtl/ks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ks_pkg: shared types and constants
// Widths, CORDIC table and the front-to-back job word of the sum block.
// ----------------------------------------------------------------------------
package ks_pkg;

  localparam int TURN_BITS    = 20;
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd3;
      5'd29: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  typedef enum logic [1:0] {
    JOB_ZERO,
    JOB_ONE,
    JOB_SUM
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] m;
    logic [15:0] n;
    logic [16:0] c;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_M,
    ST_RED_N,
    ST_NEXT_X,
    ST_EUC,
    ST_EUC_DIV,
    ST_PHASE,
    ST_PH_MUL2,
    ST_PH_DIV,
    ST_FRAC,
    ST_FRAC_DIV,
    ST_CORDIC,
    ST_ACC,
    ST_DONE
  } eng_state_t;

endpackage

// ===== rtl/ks_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ks_divider: restoring divider
// One quotient bit per cycle; quotient and remainder held until next start.
// ----------------------------------------------------------------------------
module ks_divider #(
  parameter int W = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] den;
  logic [CW-1:0] count;
  logic [W:0] trial;

  assign trial = {remainder, quotient[W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (!trial[W]) begin
        remainder <= trial[W-1:0];
        quotient  <= {quotient[W-2:0], 1'b1};
      end else begin
        remainder <= {remainder[W-2:0], quotient[W-1]};
        quotient  <= {quotient[W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== rtl/ks_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ks_front: input stage and job queue
// Classifies the modulus and queues jobs for the engine (two entries).
// ----------------------------------------------------------------------------
module ks_front #(
  parameter int MAX_MODULUS = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          ready,
  input  logic [15:0]   m_value,
  input  logic [15:0]   n_value,
  input  logic [12:0]   modulus,
  output logic          job_valid,
  input  logic          job_ready,
  output ks_pkg::job_t  job
);
  ks_pkg::job_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] fill;
  logic push, pop;
  ks_pkg::job_t cls;

  always_comb begin
    cls.m = m_value;
    cls.n = n_value;
    cls.c = {4'd0, modulus};
    if (modulus == 13'd1) cls.kind = ks_pkg::JOB_ONE;
    else if (modulus >= 13'd2 && 32'(modulus) <= MAX_MODULUS) cls.kind = ks_pkg::JOB_SUM;
    else cls.kind = ks_pkg::JOB_ZERO;
  end

  assign ready     = (fill != 2'd2);
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];
  assign push      = valid && ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end
endmodule

// ===== rtl/ks_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ks_engine: residue loop
// Per residue: extended Euclid, phase, turn fraction, CORDIC, accumulate.
// ----------------------------------------------------------------------------
module ks_engine #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  ks_pkg::job_t       job,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [29:0] sum_fixed,
  output logic signed [13:0] sum_rounded
);
  localparam int DW = 40;

  ks_pkg::eng_state_t state, state_next;

  logic [16:0] c, m, n, x;
  logic [16:0] ea, eb;
  logic signed [18:0] s0, s1;
  logic [33:0] prod;
  logic [16:0] xinv;
  logic [33:0] phase_sum;
  logic signed [47:0] acc;
  logic [19:0] frac;
  logic signed [33:0] cx, cy, cz;
  logic [4:0] step;
  logic [1:0] quad;

  logic div_start, div_busy;
  logic [DW-1:0] div_a, div_b, div_q, div_r;

  ks_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ks_pkg::ST_IDLE:
        if (job_valid) begin
          if (job.kind == ks_pkg::JOB_SUM) state_next = ks_pkg::ST_RED_M;
          else state_next = ks_pkg::ST_DONE;
        end
      ks_pkg::ST_RED_M:    if (!div_busy) state_next = ks_pkg::ST_RED_N;
      ks_pkg::ST_RED_N:    if (!div_busy) state_next = ks_pkg::ST_NEXT_X;
      ks_pkg::ST_NEXT_X:
        state_next = (x + 17'd1 >= c) ? ks_pkg::ST_DONE : ks_pkg::ST_EUC;
      ks_pkg::ST_EUC:
        if (eb == 17'd0) state_next = (ea == 17'd1) ? ks_pkg::ST_PHASE : ks_pkg::ST_NEXT_X;
        else state_next = ks_pkg::ST_EUC_DIV;
      ks_pkg::ST_EUC_DIV:  if (!div_busy) state_next = ks_pkg::ST_EUC;
      ks_pkg::ST_PHASE:    state_next = ks_pkg::ST_PH_MUL2;
      ks_pkg::ST_PH_MUL2:  state_next = ks_pkg::ST_PH_DIV;
      ks_pkg::ST_PH_DIV:   if (!div_busy) state_next = ks_pkg::ST_FRAC;
      ks_pkg::ST_FRAC:     state_next = ks_pkg::ST_FRAC_DIV;
      ks_pkg::ST_FRAC_DIV: if (!div_busy) state_next = ks_pkg::ST_CORDIC;
      ks_pkg::ST_CORDIC:
        if (step == 5'(ks_pkg::CORDIC_STEPS - 1)) state_next = ks_pkg::ST_ACC;
      ks_pkg::ST_ACC:      state_next = ks_pkg::ST_NEXT_X;
      ks_pkg::ST_DONE:     if (res_ready) state_next = ks_pkg::ST_IDLE;
      default:             state_next = ks_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready = (state == ks_pkg::ST_IDLE);
    res_valid = (state == ks_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ks_pkg::ST_IDLE;
    else state <= state_next;
  end

  // divider launches: each state picks the operands of the division that the state it enters next waits on
  always_comb begin
    div_start = 1'b0;
    div_a = '0;
    div_b = {23'd0, c};
    unique case (state)
      ks_pkg::ST_IDLE: begin
        div_start = job_valid && job.kind == ks_pkg::JOB_SUM;
        div_a = {24'd0, job.m};
        div_b = {23'd0, job.c};
      end
      ks_pkg::ST_RED_M: begin
        div_start = !div_busy;
        div_a = {23'd0, n};
      end
      ks_pkg::ST_EUC: begin
        div_start = (eb != 17'd0);
        div_a = {23'd0, ea};
        div_b = {23'd0, eb};
      end
      ks_pkg::ST_PH_MUL2: begin
        div_start = 1'b1;
        div_a = {6'd0, phase_sum};
      end
      ks_pkg::ST_FRAC: begin
        div_start = 1'b1;
        div_a = {3'd0, prod[16:0], 20'd0};
      end
      default: ;
    endcase
  end

  logic signed [33:0] dx, dy;
  logic signed [34:0] s1q;
  logic signed [18:0] s_red;
  logic signed [63:0] fix_val;
  logic signed [47:0] rnd;
  logic signed [33:0] cosq;
  logic signed [33:0] cos_fix;
  localparam int SH = 30 - FRAC_BITS;

  assign dx = cx >>> step;
  assign dy = cy >>> step;
  assign s1q = s1 * $signed({1'b0, div_q[15:0]});
  assign s_red = (s0 < 0) ? s0 + $signed({2'b0, c}) : s0;

  always_comb begin
    unique case (quad)
      2'd0: cosq = cx;
      2'd1: cosq = -cy;
      2'd2: cosq = -cx;
      default: cosq = cy;
    endcase
    if (cosq >= 0) cos_fix = (cosq + (34'sd1 <<< (SH - 1))) >>> SH;
    else cos_fix = -((-cosq + (34'sd1 <<< (SH - 1))) >>> SH);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ks_pkg::ST_IDLE: begin
        c <= job.c;
        n <= {1'b0, job.n};
        x <= '0;
        acc <= (job.kind == ks_pkg::JOB_ONE) ? (48'sd1 <<< FRAC_BITS) : 48'sd0;
      end
      ks_pkg::ST_RED_M: if (!div_busy) m <= div_r[16:0];
      ks_pkg::ST_RED_N: if (!div_busy) n <= div_r[16:0];
      ks_pkg::ST_NEXT_X: begin
        x  <= x + 17'd1;
        ea <= x + 17'd1;
        eb <= c;
        s0 <= 19'sd1;
        s1 <= 19'sd0;
      end
      ks_pkg::ST_EUC_DIV:
        if (!div_busy) begin
          ea <= eb;
          eb <= div_r[16:0];
          s0 <= s1;
          s1 <= s0 - s1q[18:0];
        end
      ks_pkg::ST_PHASE: begin
        xinv <= s_red[16:0];
        prod <= m * x;
      end
      ks_pkg::ST_PH_MUL2: ;
      ks_pkg::ST_PH_DIV: if (!div_busy) prod <= {17'd0, div_r[16:0]};
      ks_pkg::ST_FRAC_DIV:
        if (!div_busy) begin
          quad <= div_q[19:18];
          cz   <= $signed({4'b0, div_q[17:0], 12'd0});
          cx   <= ks_pkg::CORDIC_GAIN;
          cy   <= '0;
          step <= '0;
        end
      ks_pkg::ST_CORDIC: begin
        if (cz >= 0) begin
          cx <= cx - dy;
          cy <= cy + dx;
          cz <= cz - ks_pkg::atan_turn(step);
        end else begin
          cx <= cx + dy;
          cy <= cy - dx;
          cz <= cz + ks_pkg::atan_turn(step);
        end
        step <= step + 5'd1;
      end
      ks_pkg::ST_ACC: acc <= acc + 48'(cos_fix);
      default: ;
    endcase
  end

  // second phase product: n * xinv, added combinationally to the registered m * x
  always_comb phase_sum = 34'(prod) + 34'(n) * 34'(xinv);

  // final outputs with saturation
  always_comb begin
    fix_val = 64'(acc);
    if (acc >= 0) rnd = (acc + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    else rnd = -((-acc + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    if (fix_val > 64'sd536870911) sum_fixed = 30'sh1FFFFFFF;
    else if (fix_val < -64'sd536870912) sum_fixed = 30'sh20000000;
    else sum_fixed = acc[29:0];
    if (rnd > 48'sd8191) sum_rounded = 14'sh1FFF;
    else if (rnd < -48'sd8192) sum_rounded = 14'sh2000;
    else sum_rounded = rnd[13:0];
  end
endmodule

// ===== rtl/kloosterman_sum_real.sv =====
`timescale 1ns / 1ps
// Flow: a word with c < 2 or c out of range goes straight to its result; otherwise
//   m and n are reduced mod c, each x in 1..c-1 runs its Euclid quotient steps, and
//   each coprime x adds phase, fraction and 30 CORDIC steps, on the shared 40-bit divider.
// Throughput: one word at a time in the engine; the front queues two more.
// Reset: synchronous, active high; clears queue and engine state, no result.
// ----------------------------------------------------------------------------
// kloosterman_sum_real: real part of a Kloosterman sum
// Front queue classifies words; engine iterates residues with CORDIC cosine.
// ----------------------------------------------------------------------------
module kloosterman_sum_real #(
  parameter int MAX_MODULUS = 4096,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        m_value,
  input  logic [15:0]        n_value,
  input  logic [12:0]        modulus,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [29:0] sum_fixed,
  output logic signed [13:0] sum_rounded
);
  logic job_valid, job_ready;
  ks_pkg::job_t job;

  // front: classify modulus, queue the word
  ks_front #(.MAX_MODULUS(MAX_MODULUS)) u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready),
    .m_value(m_value), .n_value(n_value), .modulus(modulus),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  // back: residue loop, result held until taken
  ks_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .res_valid(out_valid), .res_ready(out_ready),
    .sum_fixed(sum_fixed), .sum_rounded(sum_rounded)
  );

  // a result must not drop before it is taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  // a queued job is only taken when engine is idle
  assert property (@(posedge clk) disable iff (rst)
    job_ready |-> !out_valid)
    else $error("engine accepts while result pending");
endmodule
